/* rtl/plane_frame_builder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the plane frame builder
// Shorthand for clocked implication checks on the block's own clock and reset.
// ----------------------------------------------------------------------------
`ifndef PLANE_FRAME_BUILDER_ASSERT_SVH
`define PLANE_FRAME_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfb_pkg.sv */
// ----------------------------------------------------------------------------
// Plane frame builder package
// Item types, frame type, vector kinds and fixed widths shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int VAL_W   = 32;
  localparam int TOL_W   = 16;
  localparam int PROD_W  = 64;
  localparam int ROOT_W  = 32;
  localparam int SQR_W   = 66;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ORIGIN,
    KIND_AXIS_U,
    KIND_AXIS_V
  } kind_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] coef_a;
    logic signed [VAL_W-1:0] coef_b;
    logic signed [VAL_W-1:0] coef_c;
    logic signed [VAL_W-1:0] coef_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              vector_kind;
    logic signed [VAL_W-1:0] comp_x;
    logic signed [VAL_W-1:0] comp_y;
    logic signed [VAL_W-1:0] comp_z;
    logic                    degenerate;
    logic                    last_of_frame;
  } out_item_t;

  typedef logic [2:0][VAL_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t n;
    vec3_t org;
    vec3_t eu;
    vec3_t ev;
    logic  degen;
  } frame_t;

endpackage

/* rtl/pfb_if.sv */
// ----------------------------------------------------------------------------
// Plane frame builder channels
// Valid/ready channels for plane items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfb_in_if;
  import pfb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfb_out_if;
  import pfb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfb_cfg_if;
  import pfb_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/pfb_core.sv */
// ----------------------------------------------------------------------------
// Plane frame builder arithmetic pipeline
// Squares, two rounded square roots, restoring divisions and cross products,
// one step per register stage, stalled as a whole from the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfb_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pfb_pkg::in_item_t       in_data_i,
  input  logic [pfb_pkg::TOL_W-1:0] tol_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pfb_pkg::frame_t         out_frame_o
);
  import pfb_pkg::*;

  localparam int F        = FRAC_BITS;
  localparam int OW       = (PROD_W + F + 2 > 96) ? PROD_W + F + 2 : 96;
  localparam int SQ_STEPS = ROOT_W;
  localparam int OD_STEPS = VAL_W;

  localparam int ST_MUL   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_LEN   = ST_SQ + SQ_STEPS;
  localparam int ST_DIV   = ST_LEN + 1;
  localparam int ST_RND   = ST_DIV + OD_STEPS;
  localparam int ST_SEL   = ST_RND + 1;
  localparam int ST_WMUL  = ST_SEL + 1;
  localparam int ST_W     = ST_WMUL + 1;
  localparam int ST_WSQ   = ST_W + 1;
  localparam int ST_WSUM  = ST_WSQ + 1;
  localparam int ST_WQ    = ST_WSUM + 1;
  localparam int ST_WLEN  = ST_WQ + SQ_STEPS;
  localparam int ST_EDIV  = ST_WLEN + 1;
  localparam int ST_ERND  = ST_EDIV + F + 1;
  localparam int ST_EMUL  = ST_ERND + 1;
  localparam int ST_EV    = ST_EMUL + 1;
  localparam int NS       = ST_EV + 1;

  typedef struct packed {
    logic [2:0]                    cneg;
    logic                          dneg;
    logic [2:0][VAL_W-1:0]         cm;
    logic [VAL_W-1:0]              dm;
    logic [2:0][PROD_W-1:0]        sq;
    logic [2:0][PROD_W-1:0]        pm;
    logic [PROD_W-1:0]             l2;
    logic [SQR_W-1:0]              sr;
    logic [ROOT_W-1:0]             ss;
    logic [ROOT_W-1:0]             den;
    logic                          degen;
    logic [2:0][PROD_W-1:0]        nr;
    logic [2:0][VAL_W-1:0]         nq;
    logic [2:0][OW-1:0]            orr;
    logic [2:0][VAL_W-1:0]         oq;
    logic [2:0]                    osat;
    logic [2:0][VAL_W-1:0]         n;
    logic [2:0][VAL_W-1:0]         org;
    logic [1:0]                    k;
    logic [2:0][PROD_W-1:0]        nkn;
    logic [2:0][VAL_W-1:0]         w;
    logic [2:0][VAL_W-1:0]         eu;
    logic [5:0][PROD_W-1:0]        pr;
    logic [2:0][VAL_W-1:0]         ev;
  } item_t;

  function automatic logic [VAL_W-1:0] abs32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? -v : v;
  endfunction

  function automatic logic [VAL_W-1:0] drop_frac(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] q;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q = (m + (PROD_W'(1) << (F - 1))) >> F;
    return v[PROD_W-1] ? VAL_W'(-q) : VAL_W'(q);
  endfunction

  function automatic logic [PROD_W-1:0] smul(input logic signed [VAL_W-1:0] a,
                                             input logic signed [VAL_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic item_t sqrt_step(input item_t it, input int b);
    item_t o;
    logic [SQR_W-1:0] term;
    o = it;
    term = ({{(SQR_W-ROOT_W){1'b0}}, it.ss} << (b + 1)) | (SQR_W'(1) << (2 * b));
    if (it.sr >= term) begin
      o.sr    = it.sr - term;
      o.ss[b] = 1'b1;
    end
    return o;
  endfunction

  function automatic item_t ndiv_step(input item_t it, input int b);
    item_t o;
    logic [PROD_W-1:0] dv;
    o = it;
    dv = {{(PROD_W-ROOT_W){1'b0}}, it.den} << b;
    for (int i = 0; i < 3; i++) begin
      if (it.nr[i] >= dv) begin
        o.nr[i]    = it.nr[i] - dv;
        o.nq[i][b] = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic logic [ROOT_W-1:0] root_round(input item_t it);
    return it.ss + ROOT_W'(it.sr > {{(SQR_W-ROOT_W){1'b0}}, it.ss});
  endfunction

  item_t             stg_q [NS];
  item_t             stg_d [NS];
  logic [NS-1:0]     vld_q;
  logic              adv;

  assign adv         = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NS-1];

  assign out_frame_o.n     = stg_q[NS-1].n;
  assign out_frame_o.org   = stg_q[NS-1].org;
  assign out_frame_o.eu    = stg_q[NS-1].eu;
  assign out_frame_o.ev    = stg_q[NS-1].ev;
  assign out_frame_o.degen = stg_q[NS-1].degen;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    item_t nxt;
    assign stg_d[s] = nxt;

    if (s == 0) begin : g_in
      always_comb begin
        logic [2:0][VAL_W-1:0] cv;
        cv = {in_data_i.coef_c, in_data_i.coef_b, in_data_i.coef_a};
        nxt = '0;
        for (int i = 0; i < 3; i++) begin
          nxt.cneg[i] = cv[i][VAL_W-1];
          nxt.cm[i]   = abs32(cv[i]);
        end
        nxt.dneg = in_data_i.coef_d[VAL_W-1];
        nxt.dm   = abs32(in_data_i.coef_d);
      end
    end else if (s == ST_MUL) begin : g_mul
      always_comb begin
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          nxt.sq[i] = stg_q[s-1].cm[i] * stg_q[s-1].cm[i];
          nxt.pm[i] = stg_q[s-1].dm * stg_q[s-1].cm[i];
        end
      end
    end else if (s == ST_SUM || s == ST_WSUM) begin : g_sum
      always_comb begin
        logic [PROD_W-1:0] acc;
        nxt = stg_q[s-1];
        acc = stg_q[s-1].sq[0] + stg_q[s-1].sq[1] + stg_q[s-1].sq[2];
        if (s == ST_SUM) begin
          nxt.l2 = acc;
        end
        nxt.sr = {{(SQR_W-PROD_W){1'b0}}, acc};
        nxt.ss = '0;
      end
    end else if (s >= ST_SQ && s < ST_SQ + SQ_STEPS) begin : g_sq
      always_comb nxt = sqrt_step(stg_q[s-1], ST_SQ + SQ_STEPS - 1 - s);
    end else if (s >= ST_WQ && s < ST_WQ + SQ_STEPS) begin : g_wq
      always_comb nxt = sqrt_step(stg_q[s-1], ST_WQ + SQ_STEPS - 1 - s);
    end else if (s == ST_LEN) begin : g_len
      always_comb begin
        logic [ROOT_W-1:0] len;
        nxt = stg_q[s-1];
        len = root_round(stg_q[s-1]);
        nxt.den   = len;
        nxt.degen = (len <= {{(ROOT_W-TOL_W){1'b0}}, tol_i}) || (len == '0);
        nxt.nq    = '0;
        nxt.oq    = '0;
        nxt.osat  = '0;
        for (int i = 0; i < 3; i++) begin
          nxt.nr[i]  = {{(PROD_W-VAL_W){1'b0}}, stg_q[s-1].cm[i]} << F;
          nxt.orr[i] = {{(OW-PROD_W){1'b0}}, stg_q[s-1].pm[i]} << F;
        end
      end
    end else if (s >= ST_DIV && s < ST_DIV + OD_STEPS) begin : g_div
      localparam int J  = s - ST_DIV;
      localparam int OB = OD_STEPS - 1 - J;
      localparam int NB = (J <= F) ? F - J : 0;
      always_comb begin
        item_t t;
        logic [OW-1:0] dv;
        t = (J <= F) ? ndiv_step(stg_q[s-1], NB) : stg_q[s-1];
        dv = {{(OW-PROD_W){1'b0}}, stg_q[s-1].l2} << OB;
        for (int i = 0; i < 3; i++) begin
          if (J == 0) begin
            t.osat[i] = stg_q[s-1].orr[i] >= dv;
          end else if (!stg_q[s-1].osat[i] && stg_q[s-1].orr[i] >= dv) begin
            t.orr[i]     = stg_q[s-1].orr[i] - dv;
            t.oq[i][OB]  = 1'b1;
          end
        end
        nxt = t;
      end
    end else if (s == ST_RND) begin : g_rnd
      always_comb begin
        logic [VAL_W-1:0] nm;
        logic [VAL_W:0]   om;
        logic             sat;
        logic             neg;
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          nm = stg_q[s-1].nq[i] + VAL_W'((stg_q[s-1].nr[i] << 1) >=
               {{(PROD_W-ROOT_W){1'b0}}, stg_q[s-1].den});
          nxt.n[i] = stg_q[s-1].cneg[i] ? -nm : nm;
          om = {1'b0, stg_q[s-1].oq[i]} + (VAL_W+1)'((stg_q[s-1].orr[i] << 1) >=
               {{(OW-PROD_W){1'b0}}, stg_q[s-1].l2});
          sat = stg_q[s-1].osat[i] || om[VAL_W] || om[VAL_W-1];
          neg = stg_q[s-1].dneg ^ stg_q[s-1].cneg[i];
          if (sat) begin
            nxt.org[i] = neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
          end else begin
            nxt.org[i] = neg ? -om[VAL_W-1:0] : om[VAL_W-1:0];
          end
        end
      end
    end else if (s == ST_SEL) begin : g_sel
      always_comb begin
        logic [2:0][VAL_W-1:0] na;
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          na[i] = abs32(stg_q[s-1].n[i]);
        end
        if (na[0] <= na[1] && na[0] <= na[2]) begin
          nxt.k = 2'd0;
        end else if (na[1] <= na[2]) begin
          nxt.k = 2'd1;
        end else begin
          nxt.k = 2'd2;
        end
      end
    end else if (s == ST_WMUL) begin : g_wmul
      always_comb begin
        logic [VAL_W-1:0] nk;
        nxt = stg_q[s-1];
        nk = stg_q[s-1].n[stg_q[s-1].k];
        for (int i = 0; i < 3; i++) begin
          nxt.nkn[i] = smul(nk, stg_q[s-1].n[i]);
        end
      end
    end else if (s == ST_W) begin : g_w
      always_comb begin
        logic signed [PROD_W-1:0] t;
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          t = ((2'(i) == stg_q[s-1].k) ? (PROD_W'(1) << (2 * F)) : '0) -
              $signed(stg_q[s-1].nkn[i]);
          nxt.w[i] = drop_frac(t);
        end
      end
    end else if (s == ST_WSQ) begin : g_wsq
      always_comb begin
        logic [VAL_W-1:0] wm;
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          wm = abs32(stg_q[s-1].w[i]);
          nxt.sq[i] = wm * wm;
        end
      end
    end else if (s == ST_WLEN) begin : g_wlen
      always_comb begin
        nxt = stg_q[s-1];
        nxt.den = root_round(stg_q[s-1]);
        nxt.nq  = '0;
        for (int i = 0; i < 3; i++) begin
          nxt.nr[i] = {{(PROD_W-VAL_W){1'b0}}, abs32(stg_q[s-1].w[i])} << F;
        end
      end
    end else if (s >= ST_EDIV && s < ST_ERND) begin : g_ediv
      always_comb nxt = ndiv_step(stg_q[s-1], ST_EDIV + F - s);
    end else if (s == ST_ERND) begin : g_ernd
      always_comb begin
        logic [VAL_W-1:0] em;
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          em = stg_q[s-1].nq[i] + VAL_W'((stg_q[s-1].nr[i] << 1) >=
               {{(PROD_W-ROOT_W){1'b0}}, stg_q[s-1].den});
          if (stg_q[s-1].den == '0) begin
            nxt.eu[i] = '0;
          end else begin
            nxt.eu[i] = stg_q[s-1].w[i][VAL_W-1] ? -em : em;
          end
        end
      end
    end else if (s == ST_EMUL) begin : g_emul
      always_comb begin
        nxt = stg_q[s-1];
        nxt.pr[0] = smul(stg_q[s-1].n[1], stg_q[s-1].eu[2]);
        nxt.pr[1] = smul(stg_q[s-1].n[2], stg_q[s-1].eu[1]);
        nxt.pr[2] = smul(stg_q[s-1].n[2], stg_q[s-1].eu[0]);
        nxt.pr[3] = smul(stg_q[s-1].n[0], stg_q[s-1].eu[2]);
        nxt.pr[4] = smul(stg_q[s-1].n[0], stg_q[s-1].eu[1]);
        nxt.pr[5] = smul(stg_q[s-1].n[1], stg_q[s-1].eu[0]);
      end
    end else begin : g_ev
      always_comb begin
        nxt = stg_q[s-1];
        for (int i = 0; i < 3; i++) begin
          nxt.ev[i] = drop_frac($signed(stg_q[s-1].pr[2*i]) -
                                $signed(stg_q[s-1].pr[2*i+1]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q <= stg_d;
    end
  end

endmodule

/* rtl/plane_frame_builder.sv */
// ----------------------------------------------------------------------------
// Plane frame builder
// Each plane item A,B,C,D (signed fixed point, FRAC_BITS fraction bits) gives
// four result items in order: unit normal, foot of the perpendicular from the
// origin, in-plane axis e_u and e_v. A plane whose normal length is at or below
// the tolerance register gives a single degenerate result instead. The
// arithmetic is a pipeline of 111 + FRAC_BITS register stages, one square-root
// or division step per stage, followed by an output register. A new plane can
// enter every cycle while the pipeline has room; sustained, a full frame's four
// results and a degenerate plane's single result share the one result channel,
// which sets the pace.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "plane_frame_builder_assert.svh"

module plane_frame_builder #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfb_in_if.sink    in_i,
  pfb_out_if.source out_o,
  pfb_cfg_if.sink   cfg_i
);
  import pfb_pkg::*;

  logic             core_v;
  logic             core_rdy;
  frame_t           core_fr;
  logic [TOL_W-1:0] tol_q;
  logic             ser_v_q;
  kind_e            idx_q;
  frame_t           fr_q;
  logic             ser_last;
  logic             load;
  logic             out_fire;
  vec3_t            vec;
  out_item_t        od;

  pfb_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .tol_i       (tol_q),
    .out_valid_o (core_v),
    .out_ready_i (core_rdy),
    .out_frame_o (core_fr)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.data;
    end
  end

  assign ser_last = fr_q.degen || (idx_q == KIND_AXIS_V);
  assign out_fire = ser_v_q && out_o.ready;
  assign core_rdy = !ser_v_q || (out_o.ready && ser_last);
  assign load     = core_v && core_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      idx_q   <= KIND_NORMAL;
    end else if (load) begin
      ser_v_q <= 1'b1;
      idx_q   <= KIND_NORMAL;
    end else if (out_fire) begin
      if (ser_last) begin
        ser_v_q <= 1'b0;
      end
      idx_q <= kind_e'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fr_q <= core_fr;
    end
  end

  always_comb begin
    case (idx_q)
      KIND_NORMAL: vec = fr_q.n;
      KIND_ORIGIN: vec = fr_q.org;
      KIND_AXIS_U: vec = fr_q.eu;
      KIND_AXIS_V: vec = fr_q.ev;
      default:     vec = '0;
    endcase
    if (fr_q.degen) begin
      vec = '0;
    end
    od.vector_kind   = idx_q;
    od.comp_x        = vec[0];
    od.comp_y        = vec[1];
    od.comp_z        = vec[2];
    od.degenerate    = fr_q.degen;
    od.last_of_frame = ser_last;
  end

  assign out_o.valid = ser_v_q;
  assign out_o.data  = od;

  `PFB_ASSERT_NEXT(a_kind_order, out_o.valid && out_o.ready && !out_o.data.last_of_frame, out_o.valid && out_o.data.vector_kind == $past(out_o.data.vector_kind) + 2'd1, "result kinds out of order within a frame")
  `PFB_ASSERT_SAME(a_degen_item, out_o.valid && out_o.data.degenerate, out_o.data.last_of_frame && out_o.data.vector_kind == KIND_NORMAL && out_o.data.comp_x == 0 && out_o.data.comp_y == 0 && out_o.data.comp_z == 0, "degenerate result is not a lone zero normal")

endmodule

/* sim/plane_frame_builder_test.sv */
// ----------------------------------------------------------------------------
// Plane frame builder testbench
// Sends plane items through the block under random idling and back-pressure,
// works out the expected normal, origin and in-plane axes for each accepted
// plane and compares every result item, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plane_frame_builder_test;
  import pfb_pkg::*;

  localparam int FRAC = 16;
  localparam int SETTLE_CYCLES = 260;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfb_in_if  plane_ch ();
  pfb_out_if result_ch ();
  pfb_cfg_if tol_ch ();

  plane_frame_builder #(.FRAC_BITS(FRAC)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (plane_ch.sink),
    .out_o  (result_ch.source),
    .cfg_i  (tol_ch.sink)
  );

  out_item_t frame_results_q[$];
  logic [TOL_W-1:0] tolerance;
  int mismatches = 0;
  int planes_sent = 0;
  int degenerate_planes = 0;
  int results_checked = 0;
  int hold_cycles = 0;
  bit calm = 1'b0;

  logic      plane_rdy_s;
  logic      tol_rdy_s;
  logic      res_vld_s;
  out_item_t res_data_s;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("plane_frame_builder: mismatch");
    $finish;
  end

  // Handshake inputs change only after a rising edge, so a copy taken at the
  // falling edge holds what the next rising edge will see.
  always @(negedge clk_i) begin
    plane_rdy_s <= plane_ch.ready;
    tol_rdy_s   <= tol_ch.ready;
    res_vld_s   <= result_ch.valid;
    res_data_s  <= result_ch.data;
  end

  function automatic longint unsigned root_round(longint unsigned x);
    longint unsigned op, res, one;
    op = x;
    res = 0;
    one = 64'h4000_0000_0000_0000;
    while (one > op) one >>= 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    if (op > res) res++;
    return res;
  endfunction

  function automatic longint div_round(bit neg, longint unsigned mag, longint unsigned den);
    longint unsigned q, r;
    q = mag / den;
    r = mag % den;
    if (r >= den - r) q++;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint narrow(longint v);
    return div_round(v < 0, mag_of(v), 64'd1 << FRAC);
  endfunction

  function automatic longint foot_comp(longint d, longint a, longint unsigned l2);
    logic [127:0] p, q, r, lim;
    bit neg;
    neg = (d < 0) != (a < 0);
    p = (128'(mag_of(d)) * 128'(mag_of(a))) << FRAC;
    q = p / l2;
    r = p % l2;
    lim = 128'd1 << 32;
    if (q > lim) q = lim;
    else begin
      if (r >= 128'(l2) - r) q++;
      if (q > lim) q = lim;
    end
    if (neg) return q >= 128'd2147483648 ? -64'sd2147483648 : -longint'(q);
    return q > 128'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic out_item_t make_result(kind_e kind, longint v[3], bit degen, bit last);
    out_item_t o;
    o.vector_kind   = kind;
    o.comp_x        = v[0][31:0];
    o.comp_y        = v[1][31:0];
    o.comp_z        = v[2][31:0];
    o.degenerate    = degen;
    o.last_of_frame = last;
    return o;
  endfunction

  task automatic predict_frame(in_item_t it);
    longint c[3], n[3], org[3], w[3], eu[3], ev[3], zero[3], t, d;
    longint unsigned l2, len, wl2, wlen;
    int k;
    c[0] = it.coef_a;
    c[1] = it.coef_b;
    c[2] = it.coef_c;
    d = it.coef_d;
    zero = '{0, 0, 0};
    l2 = 0;
    for (int i = 0; i < 3; i++) l2 += mag_of(c[i]) * mag_of(c[i]);
    len = root_round(l2);
    if (len <= tolerance || len == 0) begin
      frame_results_q = {frame_results_q, make_result(KIND_NORMAL, zero, 1'b1, 1'b1)};
      degenerate_planes++;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      n[i] = div_round(c[i] < 0, mag_of(c[i]) << FRAC, len);
      org[i] = foot_comp(d, c[i], l2);
    end
    if (mag_of(n[0]) <= mag_of(n[1]) && mag_of(n[0]) <= mag_of(n[2])) k = 0;
    else if (mag_of(n[1]) <= mag_of(n[2])) k = 1;
    else k = 2;
    wl2 = 0;
    for (int i = 0; i < 3; i++) begin
      t = -(n[k] * n[i]);
      if (i == k) t += longint'(1) << (2 * FRAC);
      w[i] = narrow(t);
      wl2 += mag_of(w[i]) * mag_of(w[i]);
    end
    wlen = root_round(wl2);
    for (int i = 0; i < 3; i++)
      eu[i] = wlen == 0 ? 0 : div_round(w[i] < 0, mag_of(w[i]) << FRAC, wlen);
    ev[0] = narrow(n[1] * eu[2] - n[2] * eu[1]);
    ev[1] = narrow(n[2] * eu[0] - n[0] * eu[2]);
    ev[2] = narrow(n[0] * eu[1] - n[1] * eu[0]);
    frame_results_q = {frame_results_q, make_result(KIND_NORMAL, n, 1'b0, 1'b0)};
    frame_results_q = {frame_results_q, make_result(KIND_ORIGIN, org, 1'b0, 1'b0)};
    frame_results_q = {frame_results_q, make_result(KIND_AXIS_U, eu, 1'b0, 1'b0)};
    frame_results_q = {frame_results_q, make_result(KIND_AXIS_V, ev, 1'b0, 1'b1)};
  endtask

  // The receiver hold-off is counted down here, one step per cycle.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Result side: checks each accepted item and sets ready for the next edge.
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (res_vld_s && result_ch.ready) begin
        results_checked++;
        if (frame_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", res_data_s);
        end else begin
          want = frame_results_q.pop_front();
          if (res_data_s !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result differs: expected %p, got %p", want, res_data_s);
          end
        end
      end
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic send_plane(in_item_t it);
    plane_ch.valid <= 1'b1;
    plane_ch.data  <= it;
    do @(posedge clk_i); while (!plane_rdy_s);
    predict_frame(it);
    planes_sent++;
    if (!calm && $urandom_range(99) < 31) begin
      plane_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    plane_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    tol_ch.valid <= 1'b1;
    tol_ch.data  <= value;
    do @(posedge clk_i); while (!tol_rdy_s);
    tol_ch.valid <= 1'b0;
    tolerance = value;
  endtask

  function automatic in_item_t plane_of(int a, int b, int c, int d);
    in_item_t it;
    it.coef_a = a;
    it.coef_b = b;
    it.coef_c = c;
    it.coef_d = d;
    return it;
  endfunction

  function automatic logic signed [31:0] random_coef();
    logic signed [31:0] v;
    v = $urandom();
    case ($urandom_range(3))
      0: return v;
      1: return v >>> $urandom_range(8, 30);
      2: return v >>> $urandom_range(12, 18);
      default: return (v >>> 31) ^ $urandom_range(0, 3);
    endcase
  endfunction

  function automatic in_item_t random_plane();
    in_item_t it;
    it.coef_a = random_coef();
    it.coef_b = random_coef();
    it.coef_c = random_coef();
    it.coef_d = $urandom_range(1) ? $urandom() : random_coef();
    return it;
  endfunction

  task automatic test_special_planes();
    const int mx = 32'sh7fff_ffff;
    const int mn = 32'sh8000_0000;
    const int one = 32'sh0001_0000;
    send_plane(plane_of(0, 0, 0, 0));
    send_plane(plane_of(0, 0, 1, mx));
    send_plane(plane_of(0, 0, 2, mx));
    send_plane(plane_of(2, 0, 0, mn));
    send_plane(plane_of(one, 0, 0, one));
    send_plane(plane_of(0, one, 0, -one));
    send_plane(plane_of(0, 0, -one, 5 * one));
    send_plane(plane_of(one, one, one, one));
    send_plane(plane_of(-one, one, -one, 0));
    send_plane(plane_of(3 * one, one, 2 * one, 7));
    send_plane(plane_of(one, 3 * one, 2 * one, -7));
    send_plane(plane_of(2 * one, 3 * one, one, mx));
    send_plane(plane_of(2 * one, 2 * one, one, mn));
    send_plane(plane_of(mx, mx, mx, mx));
    send_plane(plane_of(mn, mn, mn, mn));
    send_plane(plane_of(mn, mx, 0, mn));
    send_plane(plane_of(mx, mn, 1, -1));
    send_plane(plane_of(-1, -1, -1, mx));
    send_plane(plane_of(32'shffff, 0, 0, mx));
    send_plane(plane_of(0, 32'sh10000, 32'sh1, mn));
  endtask

  task automatic test_random_planes(int count);
    repeat (count) send_plane(random_plane());
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(16'd0);
    send_plane(plane_of(0, 0, 0, 1));
    send_plane(plane_of(1, 0, 0, 32'sh7fff_ffff));
    test_random_planes(20);
    write_tolerance(16'hffff);
    send_plane(plane_of(32'shffff, 0, 0, 1));
    send_plane(plane_of(32'sh10000, 0, 0, 1));
    send_plane(plane_of(32'shb505, 32'shb505, 0, 1));
    test_random_planes(20);
    write_tolerance(16'($urandom()));
    test_random_planes(20);
    write_tolerance(16'd1);
  endtask

  task automatic test_back_pressure();
    hold_cycles = 600;
    test_random_planes(160);
    drain_results();
    test_random_planes(10);
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_planes(50);
    calm = 1'b0;
  endtask

  initial begin
    plane_ch.valid = 1'b0;
    plane_ch.data  = '0;
    tol_ch.valid   = 1'b0;
    tol_ch.data    = '0;
    tolerance      = 16'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_planes();
    test_tolerance_extremes();
    test_back_pressure();
    test_steady_stream();
    test_random_planes(25);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d planes, %0d of them degenerate; checked %0d result items.",
             planes_sent, degenerate_planes, results_checked);
    $display("Tolerance register was run at zero, full scale, a random value and one.");
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("plane_frame_builder: match");
    end else begin
      $display("plane_frame_builder: mismatch");
    end
    $finish;
  end

endmodule
